/* rtl/core/sha1md_pkg.sv */
// Shared types and constants for the SHA-1 message digest core.
// Holds the queued word item and the SHA-1 initial chaining and round constants.
// No dependencies.
package sha1md_pkg;

    typedef struct packed {
        logic [31:0] word;
        logic        final_block;
    } t_word_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned ROUNDS_PER_BLOCK = 80;
    localparam int unsigned DIGEST_WORDS = 5;

endpackage

/* rtl/core/sha1md_front.sv */
// Front end: accepts message bytes, packs them into big-endian words and adds padding.
// Emits 16 words per block, with the length words and a final-block mark at the end.
// Depends on sha1md_pkg.
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_data_byte,
    input  logic          i_byte_present,
    input  logic          i_end_of_message,
    input  logic          i_queue_full,
    output logic          o_word_valid,
    output t_word_item    o_word_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAD  = 2'd1;
    localparam logic [1:0] S_ZERO = 2'd2;
    localparam logic [1:0] S_LEN  = 2'd3;
    localparam logic [3:0] LEN_WORD_SLOT = 4'd14;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [31:0] r_acc, n_acc;
    logic [60:0] r_byte_cnt, n_byte_cnt;

    logic        w_accept;
    logic [31:0] w_acc_byte;

    function automatic logic [31:0] place_byte(input logic [31:0] acc, input logic [1:0] pos,
                                               input logic [7:0] data);
        logic [31:0] result;
        begin
            case (pos)
                2'd0:    result = {data, 24'h000000};
                2'd1:    result = {acc[31:24], data, 16'h0000};
                2'd2:    result = {acc[31:16], data, 8'h00};
                2'd3:    result = {acc[31:8], data};
                default: result = acc;
            endcase
            return result;
        end
    endfunction

    assign o_full     = (r_state != S_IDLE) || i_queue_full;
    assign w_accept   = i_push && !o_full;
    assign w_acc_byte = place_byte(r_acc, r_fill[1:0], i_data_byte);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_acc        = r_acc;
        n_byte_cnt   = r_byte_cnt;
        o_word_valid = 1'b0;
        o_word_item  = '{word: w_acc_byte, final_block: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_byte_present) begin
                        n_acc      = w_acc_byte;
                        n_fill     = r_fill + 6'd1;
                        n_byte_cnt = r_byte_cnt + 61'd1;
                        if (r_fill[1:0] == 2'd3) begin
                            o_word_valid = 1'b1;
                        end
                    end
                    if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_word_item.word = place_byte(r_acc, r_fill[1:0], PAD_BYTE);
                if (!i_queue_full) begin
                    o_word_valid = 1'b1;
                    n_fill       = {r_fill[5:2] + 4'd1, 2'b00};
                    n_state      = S_ZERO;
                end
            end
            S_ZERO: begin
                if (r_fill[5:2] == LEN_WORD_SLOT) begin
                    o_word_item.word = r_byte_cnt[60:29];
                end else begin
                    o_word_item.word = 32'h00000000;
                end
                if (!i_queue_full) begin
                    o_word_valid = 1'b1;
                    n_fill       = r_fill + 6'd4;
                    if (r_fill[5:2] == LEN_WORD_SLOT) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                o_word_item = '{word: {r_byte_cnt[28:0], 3'b000}, final_block: 1'b1};
                if (!i_queue_full) begin
                    o_word_valid = 1'b1;
                    n_fill       = 6'd0;
                    n_byte_cnt   = 61'd0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= 6'd0;
            r_byte_cnt <= 61'd0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

/* rtl/core/sha1md_fifo.sv */
// Short word queue between the front end and the compression engine.
// Register-based circular buffer with a fill count.
// Depends on sha1md_pkg.
module sha1md_fifo
    import sha1md_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_word_item    i_item,
    input  logic          i_pop,
    output t_word_item    o_item,
    output t_queue_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_word_item       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/sha1md_back.sv */
// Compression engine: loads 16 words, runs 80 rounds, updates the chaining words.
// After a final block it hands the five digest words to an output buffer.
// Depends on sha1md_pkg.
module sha1md_back
    import sha1md_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_word_item    i_item,
    input  logic          i_queue_empty,
    output logic          o_queue_pop,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);

    localparam logic [1:0] B_LOAD   = 2'd0;
    localparam logic [1:0] B_ROUND  = 2'd1;
    localparam logic [1:0] B_FINISH = 2'd2;
    localparam logic [3:0] LOAD_LAST  = 4'(WORDS_PER_BLOCK - 1);
    localparam logic [6:0] ROUND_LAST = 7'(ROUNDS_PER_BLOCK - 1);
    localparam logic [2:0] INDEX_LAST = 3'(DIGEST_WORDS - 1);

    logic [1:0]  r_state;
    logic [31:0] r_w [WORDS_PER_BLOCK];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [DIGEST_WORDS];
    logic [31:0] r_dig [DIGEST_WORDS];
    logic [6:0]  r_round;
    logic [3:0]  r_load_cnt;
    logic        r_final;
    logic        r_ovalid;
    logic [2:0]  r_oidx;

    logic [31:0] w_f, w_k, w_t, w_sched;
    logic [31:0] w_sum [DIGEST_WORDS];
    logic        w_shift_w;

    assign o_queue_pop   = (r_state == B_LOAD) && !i_queue_empty;
    assign w_shift_w     = o_queue_pop || (r_state == B_ROUND);
    assign empty         = !r_ovalid;
    assign o_digest_word = r_dig[0];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == INDEX_LAST);

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_ROUND0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_ROUND1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_ROUND2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_ROUND3;
        end
        w_t     = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
        w_sched = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_sum[0] = r_h[0] + r_a;
        w_sum[1] = r_h[1] + r_b;
        w_sum[2] = r_h[2] + r_c;
        w_sum[3] = r_h[3] + r_d;
        w_sum[4] = r_h[4] + r_e;
    end

    always_ff @(posedge i_clk) begin
        if (w_shift_w) begin
            for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            if (r_state == B_LOAD) begin
                r_w[WORDS_PER_BLOCK - 1] <= i_item.word;
            end else begin
                r_w[WORDS_PER_BLOCK - 1] <= {w_sched[30:0], w_sched[31]};
            end
        end
        if (r_state == B_ROUND) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else if (o_queue_pop && (r_load_cnt == LOAD_LAST)) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end
        if ((r_state == B_FINISH) && r_final && !r_ovalid) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_dig[i] <= w_sum[i];
            end
        end else if (r_ovalid && pop) begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                r_dig[i] <= r_dig[i + 1];
            end
        end
        if (o_queue_pop && (r_load_cnt == LOAD_LAST)) begin
            r_final <= i_item.final_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_LOAD;
            r_load_cnt <= 4'd0;
            r_round    <= 7'd0;
            r_ovalid   <= 1'b0;
            r_oidx     <= 3'd0;
            r_h[0]     <= H0_INIT;
            r_h[1]     <= H1_INIT;
            r_h[2]     <= H2_INIT;
            r_h[3]     <= H3_INIT;
            r_h[4]     <= H4_INIT;
        end else begin
            if (r_ovalid && pop) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == INDEX_LAST) begin
                    r_ovalid <= 1'b0;
                end
            end
            case (r_state)
                B_LOAD: begin
                    if (o_queue_pop) begin
                        r_load_cnt <= r_load_cnt + 4'd1;
                        if (r_load_cnt == LOAD_LAST) begin
                            r_round <= 7'd0;
                            r_state <= B_ROUND;
                        end
                    end
                end
                B_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == ROUND_LAST) begin
                        r_state <= B_FINISH;
                    end
                end
                B_FINISH: begin
                    if (!r_final) begin
                        for (int i = 0; i < DIGEST_WORDS; i++) begin
                            r_h[i] <= w_sum[i];
                        end
                        r_state <= B_LOAD;
                    end else if (!r_ovalid) begin
                        r_h[0]   <= H0_INIT;
                        r_h[1]   <= H1_INIT;
                        r_h[2]   <= H2_INIT;
                        r_h[3]   <= H3_INIT;
                        r_h[4]   <= H4_INIT;
                        r_ovalid <= 1'b1;
                        r_oidx   <= 3'd0;
                        r_state  <= B_LOAD;
                    end
                end
                default: begin
                    r_state <= B_LOAD;
                end
            endcase
        end
    end

endmodule

/* rtl/core/sha1_message_digest_core.sv */
// Top level of the SHA-1 message digest core.
// Connects the byte front end, the word queue and the compression engine.
// Depends on sha1md_pkg, sha1md_front, sha1md_fifo and sha1md_back.

// Bytes enter one per cycle while full is low (the front end is not padding and the queue has
// room) and are packed into words that wait in a short queue while the compression engine
// works; each 64-byte block is loaded as 16 words, run through 80 rounds and then added into
// the chaining words, so long messages are paced by the single-round loop and by QUEUE_DEPTH
// words of buffering. After the end mark the front end emits the padding words, and the five
// digest words follow the last block in order, word 0 first, held in an output buffer so the
// next message can start streaming in while they wait to be taken.
module sha1_message_digest_core
    import sha1md_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_word_item    w_front_item;
    t_word_item    w_queue_item;
    t_queue_status w_queue_status;
    logic          w_front_valid;
    logic          w_queue_pop;

    sha1md_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .i_queue_full     (w_queue_status.full),
        .o_word_valid     (w_front_valid),
        .o_word_item      (w_front_item)
    );

    sha1md_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_front_valid),
        .i_item   (w_front_item),
        .i_pop    (w_queue_pop),
        .o_item   (w_queue_item),
        .o_status (w_queue_status)
    );

    sha1md_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_queue_item),
        .i_queue_empty (w_queue_status.empty),
        .o_queue_pop   (w_queue_pop),
        .empty         (empty),
        .pop           (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_front_valid && w_queue_status.full))
        else $error("front end transfers a word into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_queue_pop && w_queue_status.empty))
        else $error("engine takes a word from an empty queue");

    a_index_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_word) |=>
        (!empty && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest word index does not advance after a transfer");
`endif

endmodule

/* dv/tb_sha1_message_digest_core.sv */
// Testbench for sha1_message_digest_core: byte items go in through a push/full queue port and
// digest words come out through an empty/pop port, checked against a SHA-1 model kept here.
// Depends on sha1md_pkg and the sha1_message_digest_core RTL.
`timescale 1ns / 1ps

module tb_sha1_message_digest_core;
    import sha1md_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       hold;
    } t_byte_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    t_byte_item   pending_items[$];
    t_digest_word expected_words[$];
    t_byte_item   sent_item;
    t_digest_word want_word;
    int           items_sent = 0;
    int           words_seen = 0;
    int           error_count = 0;
    int           stim_items = 0;

    logic [31:0] hash_state[5];
    logic [63:0] msg_bits;
    logic [7:0]  blk_bytes[64];
    int          blk_fill;

    sha1_message_digest_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_data_byte(i_data_byte),
        .i_byte_present(i_byte_present),
        .i_end_of_message(i_end_of_message),
        .empty(empty),
        .pop(pop),
        .o_digest_word(o_digest_word),
        .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void restart_digest();
        hash_state[0] = H0_INIT;
        hash_state[1] = H1_INIT;
        hash_state[2] = H2_INIT;
        hash_state[3] = H3_INIT;
        hash_state[4] = H4_INIT;
        msg_bits = 64'd0;
        blk_fill = 0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++) begin
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                t = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
                w[r & 15] = {t[30:0], t[31]};
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void absorb_item(input t_byte_item it);
        int i;
        if (it.present) begin
            blk_bytes[blk_fill] = it.data;
            blk_fill++;
            msg_bits += 64'd8;
            if (blk_fill == 64) begin
                compress_block();
                blk_fill = 0;
            end
        end
        if (it.eom) begin
            blk_bytes[blk_fill] = PAD_BYTE;
            blk_fill++;
            if (blk_fill > 56) begin
                for (i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
                compress_block();
                blk_fill = 0;
            end
            for (i = blk_fill; i < 56; i++) blk_bytes[i] = 8'h00;
            for (i = 0; i < 8; i++) blk_bytes[63 - i] = msg_bits[8*i +: 8];
            compress_block();
            for (i = 0; i < DIGEST_WORDS; i++) begin
                expected_words.push_back('{hash_state[i], 3'(i), i == DIGEST_WORDS - 1});
            end
            restart_digest();
        end
    endfunction

    task automatic add_item(input logic [7:0] data, input logic present, input logic eom,
                            input logic hold);
        pending_items.push_back('{data, present, eom, hold});
        if (present || eom) stim_items++;
    endtask

    task automatic add_message(input int len, input logic hold);
        logic split_end;
        int n;
        split_end = (len == 0) || ($urandom_range(1) == 1);
        for (n = 0; n < len; n++) begin
            if ($urandom_range(99) < 8) add_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, !split_end && n == len - 1, hold && n == 0);
        end
        if (split_end) add_item(8'($urandom), 1'b0, 1'b1, hold && len == 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                sent_item = pending_items.pop_front();
                absorb_item(sent_item);
                items_sent++;
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (pending_items.size() != 0
                         && !(pending_items[0].hold && expected_words.size() != 0)
                         && ((items_sent >= 60 && items_sent < 110)
                             || $urandom_range(99) >= 9)) begin
                i_data_byte <= pending_items[0].data;
                i_byte_present <= pending_items[0].present;
                i_end_of_message <= pending_items[0].eom;
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %b",
                             $time, o_digest_word, o_word_index, o_last_word);
                    error_count++;
                end else begin
                    want_word = expected_words.pop_front();
                    if (o_digest_word !== want_word.word) begin
                        $display("%0t: digest word: expected %h, actual %h",
                                 $time, want_word.word, o_digest_word);
                        error_count++;
                    end
                    if (o_word_index !== want_word.index) begin
                        $display("%0t: word index: expected %0d, actual %0d",
                                 $time, want_word.index, o_word_index);
                        error_count++;
                    end
                    if (o_last_word !== want_word.last) begin
                        $display("%0t: last word: expected %b, actual %b",
                                 $time, want_word.last, o_last_word);
                        error_count++;
                    end
                end
                words_seen++;
            end
            pop <= (words_seen >= 100 && words_seen < 200) || ($urandom_range(99) >= 9);
        end
    end

    initial begin
        int pick;
        int boundary_lens[8];
        boundary_lens = '{54, 55, 56, 57, 62, 63, 64, 65};
        restart_digest();
        add_item(8'hFF, 1'b0, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, 1'b0);
        add_item(8'hA5, 1'b0, 1'b0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b1, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1, 1'b1);
        while (stim_items < 180) begin
            pick = $urandom_range(99);
            if (pick < 70) add_message($urandom_range(12), $urandom_range(99) < 5);
            else if (pick < 90) add_message(boundary_lens[$urandom_range(7)], 1'b0);
            else add_message($urandom_range(54, 13), 1'b0);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() != 0 || push) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("tb_sha1_message_digest_core: done, clean");
        end else begin
            $display("tb_sha1_message_digest_core: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_sha1_message_digest_core: done, errors");
        $finish;
    end

endmodule
